// ===== sv/bytd_pkg.sv =====
package bytd_pkg;

  // Character codes used by the decoder
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;

  // Position within one textual value
  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_PREFIX = 4'd1,
    PH_HEX_HI = 4'd2,
    PH_HEX_LO = 4'd3,
    PH_PLAIN  = 4'd4,
    PH_ESC    = 4'd5,
    PH_OCT1   = 4'd6,
    PH_OCT2   = 4'd7,
    PH_ERROR  = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADHEX = 2'd1,
    ST_ODDHEX = 2'd2,
    ST_BADESC = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       value_end;
    status_t    status;
  } out_item_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return c inside {[8'h30:8'h37]};
  endfunction

endpackage

// ===== sv/bytd_if.sv =====
interface bytd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
  modport mon    (input valid, input char_in, input last_char, input ready);
endinterface

interface bytd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_valid;
  logic       value_end;
  logic [1:0] status;

  modport source (output valid, output byte_value, output byte_valid,
                  output value_end, output status, input ready);
  modport sink   (input valid, input byte_value, input byte_valid,
                  input value_end, input status, output ready);
  modport mon    (input valid, input byte_value, input byte_valid,
                  input value_end, input status, input ready);
endinterface

// ===== sv/bytea_text_decoder.sv =====
// Channel   Dir  Payload                                        Transfer when
// in_ch     in   char_in[7:0], last_char                        valid && ready
// out_ch    out  byte_value[7:0], byte_valid, value_end,        valid && ready
//                status[1:0]
//
// One character per cycle sustained while out_ch is not stalled. A character
// is taken into the input register, decoded from there in the next cycle, and
// its result, if any, lands in the output register and shows on out_ch.
// Reset (rst_n low, synchronous) returns to start of value and empties both
// registers. A stall on out_ch holds the output register; the input register
// still drains characters that produce no result, then in_ch backs up.
module bytea_text_decoder import bytd_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  bytd_in_if.sink     in_ch,
  bytd_out_if.source  out_ch
);

  // input register
  logic      in_valid_r;
  in_item_t  in_item_r;

  // output register
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      res_have;
  out_item_t res;
  logic      out_free;
  logic      step;
  logic      in_take;

  // Output register can take a new result when empty or draining this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  // Advance the held character when its result (if any) has room to land
  assign step    = in_valid_r && (!res_have || out_free);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !in_valid_r || step;

  bytd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (in_item_r),
    .res_have (res_have),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // Payload: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.char_in   <= in_ch.char_in;
      in_item_r.last_char <= in_ch.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res_have) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_have) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.byte_value = out_item_r.byte_value;
  assign out_ch.byte_valid = out_item_r.byte_valid;
  assign out_ch.value_end  = out_item_r.value_end;
  assign out_ch.status     = out_item_r.status;

endmodule

// ===== sv/bytd_core.sv =====
module bytd_core import bytd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  output logic      res_have,
  output out_item_t res
);

  phase_t     phase_r, phase_nxt;
  logic [5:0] part_r, part_nxt;
  status_t    err_r, err_nxt;

  logic       have;
  logic [7:0] byte_v;
  logic       esc_path;
  logic [4:0] hd;
  status_t    st;
  logic [7:0] c;

  always_comb begin
    c         = item.char_in;
    hd        = hex_digit(c);
    phase_nxt = phase_r;
    part_nxt  = part_r;
    err_nxt   = err_r;
    have      = 1'b0;
    byte_v    = 8'd0;
    esc_path  = 1'b0;

    case (phase_r)
      PH_PREFIX: begin
        if (c == CH_X) begin
          phase_nxt = PH_HEX_HI;
        end else begin
          esc_path = 1'b1;
        end
      end
      PH_HEX_HI: begin
        if (!hd[4]) begin
          err_nxt   = ST_BADHEX;
          phase_nxt = PH_ERROR;
        end else begin
          part_nxt  = {2'b00, hd[3:0]};
          phase_nxt = PH_HEX_LO;
        end
      end
      PH_HEX_LO: begin
        if (!hd[4]) begin
          err_nxt   = ST_BADHEX;
          phase_nxt = PH_ERROR;
        end else begin
          byte_v    = {part_r[3:0], hd[3:0]};
          have      = 1'b1;
          part_nxt  = 6'd0;
          phase_nxt = PH_HEX_HI;
        end
      end
      PH_ESC: begin
        esc_path = 1'b1;
      end
      PH_OCT1: begin
        if (is_octal(c)) begin
          part_nxt  = {1'b0, part_r[1:0], c[2:0]};
          phase_nxt = PH_OCT2;
        end else begin
          err_nxt   = ST_BADESC;
          phase_nxt = PH_ERROR;
        end
      end
      PH_OCT2: begin
        if (is_octal(c)) begin
          byte_v    = {part_r[4:0], c[2:0]};
          have      = 1'b1;
          part_nxt  = 6'd0;
          phase_nxt = PH_PLAIN;
        end else begin
          err_nxt   = ST_BADESC;
          phase_nxt = PH_ERROR;
        end
      end
      PH_ERROR: begin
      end
      PH_PLAIN: begin
        if (c == CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else begin
          byte_v = c;
          have   = 1'b1;
        end
      end
      default: begin
        // start of value, and any code never entered
        if (c == CH_BSLASH) begin
          phase_nxt = PH_PREFIX;
        end else begin
          byte_v    = c;
          have      = 1'b1;
          phase_nxt = PH_PLAIN;
        end
      end
    endcase

    // character after a backslash in escape mode
    if (esc_path) begin
      if (c == CH_BSLASH) begin
        byte_v    = CH_BSLASH;
        have      = 1'b1;
        phase_nxt = PH_PLAIN;
      end else if (c inside {[8'h30:8'h33]}) begin
        part_nxt  = {4'd0, c[1:0]};
        phase_nxt = PH_OCT1;
      end else begin
        err_nxt   = ST_BADESC;
        phase_nxt = PH_ERROR;
      end
    end

    st = err_nxt;
    if (st == ST_OK) begin
      if (phase_nxt == PH_HEX_LO) begin
        st = ST_ODDHEX;
      end else if (phase_nxt inside {PH_PREFIX, PH_ESC, PH_OCT1, PH_OCT2}) begin
        st = ST_BADESC;
      end
    end

    if (item.last_char) begin
      res_have       = 1'b1;
      res.byte_valid = have && (st == ST_OK);
      res.byte_value = (have && (st == ST_OK)) ? byte_v : 8'd0;
      res.value_end  = 1'b1;
      res.status     = st;
      phase_nxt      = PH_START;
      part_nxt       = 6'd0;
      err_nxt        = ST_OK;
    end else begin
      res_have       = have;
      res.byte_valid = 1'b1;
      res.byte_value = byte_v;
      res.value_end  = 1'b0;
      res.status     = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      part_r  <= 6'd0;
      err_r   <= ST_OK;
    end else if (step) begin
      phase_r <= phase_nxt;
      part_r  <= part_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== sv/bytd_checker.sv =====
module bytd_checker import bytd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte_value,
  input logic       out_byte_valid,
  input logic       out_value_end,
  input logic [1:0] out_status
);

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_byte_value) && $stable(out_byte_valid)
      && $stable(out_value_end) && $stable(out_status))
    else $error("result changed while stalled");

  // Only the closing result of a value carries a status
  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_value_end |-> out_status == ST_OK)
    else $error("status on a non-final result");

  // A result in the middle of a value always carries a byte
  a_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_value_end |-> out_byte_valid)
    else $error("empty result in mid value");

  // A failed value never delivers a byte on its closing result
  a_err_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value_end && out_status != ST_OK |->
      !out_byte_valid && out_byte_value == 8'd0)
    else $error("byte delivered with error status");

  // Nothing comes out in the cycle after reset releases
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind bytea_text_decoder bytd_checker u_bytd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte_value (out_ch.byte_value),
  .out_byte_valid (out_ch.byte_valid),
  .out_value_end  (out_ch.value_end),
  .out_status     (out_ch.status)
);
